// ===== hw/rtl/lps_pkg.sv =====
// Shared constants and types of the longest palindromic subsequence unit.
package lps_pkg;

  // Fixed widths of the words on the ports.
  localparam int unsigned CharW = 8;
  localparam int unsigned LenW  = 9;

  // Default capacity of the text store and of the cell chain.
  localparam int unsigned MaxLenDefault = 256;

  // Control word that the sequencer sends to every cell of the chain.
  typedef struct packed {
    logic load_en;  // the incoming character is broadcast for loading
    logic clr_val;  // clear the score registers before a pass
    logic clr_act;  // release all cells after a pass
  } lps_ctl_t;

endpackage

// ===== hw/rtl/lps_cell.sv =====
// One processing cell of the chain: holds one text character and one column score.
module lps_cell
  import lps_pkg::*;
#(
  parameter int unsigned ValW = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lps_ctl_t         ctl_i,
  input  logic             sel_i,
  input  logic [CharW-1:0] load_char_i,
  input  logic             up_valid_i,
  input  logic             up_last_i,
  input  logic [CharW-1:0] up_char_i,
  input  logic [ValW-1:0]  up_val_i,
  output logic             dn_valid_o,
  output logic             dn_last_o,
  output logic [CharW-1:0] dn_char_o,
  output logic [ValW-1:0]  dn_val_o
);

  logic             active_q;
  logic [CharW-1:0] text_q;
  logic [ValW-1:0]  val_q, val_d;
  logic [ValW-1:0]  diag_q;
  logic             valid_q;
  logic             last_q;
  logic [CharW-1:0] char_q;

  // Score update: a match extends the diagonal, otherwise the larger neighbour wins.
  // A cell that holds no character passes the score from above unchanged.
  always_comb begin
    if (!active_q) begin
      val_d = up_val_i;
    end else if (text_q == up_char_i) begin
      val_d = diag_q + ValW'(1);
    end else if (up_val_i > val_q) begin
      val_d = up_val_i;
    end else begin
      val_d = val_q;
    end
  end

  // Control state of the cell: occupancy and the travelling valid and last flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      valid_q  <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      if (ctl_i.clr_act) begin
        active_q <= 1'b0;
      end else if (ctl_i.load_en && sel_i) begin
        active_q <= 1'b1;
      end
      valid_q <= up_valid_i;
      last_q  <= up_valid_i && up_last_i;
    end
  end

  // Held character, scores and the character word handed down the chain.
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_en && sel_i) begin
      text_q <= load_char_i;
    end
    if (ctl_i.clr_val) begin
      val_q  <= '0;
      diag_q <= '0;
    end else if (up_valid_i) begin
      val_q  <= val_d;
      diag_q <= up_val_i;
    end
    char_q <= up_char_i;
  end

  assign dn_valid_o = valid_q;
  assign dn_last_o  = last_q;
  assign dn_char_o  = char_q;
  assign dn_val_o   = val_q;

endmodule

// ===== hw/rtl/lps_chain.sv =====
// Row of cells that computes the common subsequence table one column per cell.
module lps_chain
  import lps_pkg::*;
#(
  parameter int unsigned MaxLen = MaxLenDefault,
  parameter int unsigned AddrW  = (MaxLen > 1) ? $clog2(MaxLen) : 1,
  parameter int unsigned ValW   = $clog2(MaxLen + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lps_ctl_t         ctl_i,
  input  logic [AddrW-1:0] load_idx_i,
  input  logic [CharW-1:0] load_char_i,
  input  logic             feed_valid_i,
  input  logic             feed_last_i,
  input  logic [CharW-1:0] feed_char_i,
  output logic             tail_valid_o,
  output logic             tail_last_o,
  output logic [ValW-1:0]  tail_val_o
);

  logic             link_valid [MaxLen+1];
  logic             link_last  [MaxLen+1];
  logic [CharW-1:0] link_char  [MaxLen+1];
  logic [ValW-1:0]  link_val   [MaxLen+1];

  // The head of the chain sees the empty-prefix row of zeros.
  assign link_valid[0] = feed_valid_i;
  assign link_last[0]  = feed_last_i;
  assign link_char[0]  = feed_char_i;
  assign link_val[0]   = '0;

  // Each cell loads the character whose position matches its own place.
  for (genvar k = 0; k < MaxLen; k++) begin : g_cell
    logic sel;
    assign sel = (load_idx_i == AddrW'(k));

    lps_cell #(
      .ValW (ValW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl_i),
      .sel_i       (sel),
      .load_char_i (load_char_i),
      .up_valid_i  (link_valid[k]),
      .up_last_i   (link_last[k]),
      .up_char_i   (link_char[k]),
      .up_val_i    (link_val[k]),
      .dn_valid_o  (link_valid[k+1]),
      .dn_last_o   (link_last[k+1]),
      .dn_char_o   (link_char[k+1]),
      .dn_val_o    (link_val[k+1])
    );
  end

  assign tail_valid_o = link_valid[MaxLen];
  assign tail_last_o  = link_last[MaxLen];
  assign tail_val_o   = link_val[MaxLen];

endmodule

// ===== hw/rtl/longest_palindromic_subsequence_unit.sv =====
// Top level of the longest palindromic subsequence unit: sequencer, text store, cell chain.
//
// The unit takes a string one character word at a time and, after the word marked
// last, returns one result word with the length of its longest palindromic
// subsequence and an overflow flag. Each character is written to the text store and
// into the cell of the same position. After the last character the string is
// streamed from the text store in reverse order, one character per cycle, through a
// chain of MaxLen cells, each cell holding one text character and one column of the
// longest-common-subsequence table. Input is stalled during the computation, and for
// longer while an earlier result still waits to be taken. Characters beyond MaxLen
// are dropped and flagged. A finished result waits in the output register while the
// next string loads.
module longest_palindromic_subsequence_unit
  import lps_pkg::*;
#(
  parameter int unsigned MaxLen = MaxLenDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [CharW-1:0] char_byte_i,
  input  logic             last_char_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [LenW-1:0]  subseq_length_o,
  output logic             overflow_o
);

  localparam int unsigned AddrW = (MaxLen > 1) ? $clog2(MaxLen) : 1;
  localparam int unsigned CntW  = $clog2(MaxLen + 1);
  localparam int unsigned ValW  = $clog2(MaxLen + 1);

  typedef enum logic [1:0] {
    S_LOAD,
    S_START,
    S_RUN,
    S_DRAIN
  } state_e;

  state_e           state_q;
  logic [CntW-1:0]  count_q;
  logic             ovf_q;
  logic [AddrW-1:0] addr_q;
  logic             feed_q;
  logic             feed_last_q;
  logic [CharW-1:0] rd_data_q;
  logic             out_valid_q;
  logic [LenW-1:0]  out_len_q;
  logic             out_ovf_q;

  logic [CharW-1:0] text_mem [MaxLen];

  logic             in_acc;
  logic             room;
  logic             start_run;
  logic             capture;
  logic [CntW-1:0]  count_m1;
  logic [ValW+LenW-1:0] len_ext;
  lps_ctl_t         ctl;
  logic             tail_valid;
  logic             tail_last;
  logic [ValW-1:0]  tail_val;

  // Handshake and sequencing conditions.
  assign in_stall_o = (state_q != S_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign room       = (count_q < CntW'(MaxLen));
  assign start_run  = (state_q == S_START) && !out_valid_q;
  assign capture    = (state_q == S_DRAIN) && tail_valid && tail_last;
  assign count_m1   = count_q - CntW'(1);
  assign len_ext    = {{LenW{1'b0}}, tail_val};

  // Control word for the cells.
  always_comb begin
    ctl.load_en = in_acc && room;
    ctl.clr_val = start_run;
    ctl.clr_act = capture;
  end

  // Text store: written in arrival order, read backwards during a pass.
  always_ff @(posedge clk_i) begin
    if (in_acc && room) begin
      text_mem[count_q[AddrW-1:0]] <= char_byte_i;
    end
    rd_data_q <= text_mem[addr_q];
  end

  // Sequencer with its registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      addr_q      <= '0;
      feed_q      <= 1'b0;
      feed_last_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_len_q   <= '0;
      out_ovf_q   <= 1'b0;
    end else begin
      feed_q      <= (state_q == S_RUN);
      feed_last_q <= (state_q == S_RUN) && (addr_q == '0);

      if (capture) begin
        out_valid_q <= 1'b1;
        out_len_q   <= len_ext[LenW-1:0];
        out_ovf_q   <= ovf_q;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_LOAD: begin
          if (in_acc) begin
            if (room) begin
              count_q <= count_q + CntW'(1);
            end else begin
              ovf_q <= 1'b1;
            end
            if (last_char_i) begin
              state_q <= S_START;
            end
          end
        end
        S_START: begin
          if (start_run) begin
            addr_q  <= count_m1[AddrW-1:0];
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          if (addr_q == '0) begin
            state_q <= S_DRAIN;
          end else begin
            addr_q <= addr_q - AddrW'(1);
          end
        end
        S_DRAIN: begin
          if (capture) begin
            count_q <= '0;
            ovf_q   <= 1'b0;
            state_q <= S_LOAD;
          end
        end
        default: begin
          state_q <= S_LOAD;
        end
      endcase
    end
  end

  // Chain of cells that evaluates the table.
  lps_chain #(
    .MaxLen (MaxLen),
    .AddrW  (AddrW),
    .ValW   (ValW)
  ) u_chain (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .load_idx_i   (count_q[AddrW-1:0]),
    .load_char_i  (char_byte_i),
    .feed_valid_i (feed_q),
    .feed_last_i  (feed_last_q),
    .feed_char_i  (rd_data_q),
    .tail_valid_o (tail_valid),
    .tail_last_o  (tail_last),
    .tail_val_o   (tail_val)
  );

  assign out_valid_o     = out_valid_q;
  assign subseq_length_o = out_len_q;
  assign overflow_o      = out_ovf_q;

endmodule
